// ----- rtl/core/qlif_pkg.sv -----
// ----------------------------------------------------------------------------
// qlif_pkg
// Shared types and constants for the quantized leaky integrate-and-fire
// neuron update block.
// ----------------------------------------------------------------------------
`default_nettype none

package qlif_pkg;

  localparam int CHANNEL_W   = 6;
  localparam int INT8_W      = 8;
  localparam int DECAY_W     = 16;
  localparam int THRESH_W    = 32;
  localparam int OFFSET_W    = 9;
  localparam int RATIO_W     = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int ENTRY_W     = DECAY_W + THRESH_W;

  // result queue behind the pipeline
  localparam int FIFO_DEPTH  = 8;
  localparam int PTR_W       = 3;

  localparam int SAT_MAX     = 127;
  localparam int SAT_MIN     = -128;
  localparam int SPIKE_ONE   = 1;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 24'd65536;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_UPDATE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INPUT_ZERO   = 3'd0,
    CFG_MEMBRANE_IN  = 3'd1,
    CFG_SPIKE_ZERO   = 3'd2,
    CFG_MEMBRANE_OUT = 3'd3,
    CFG_INPUT_RATIO  = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [INT8_W-1:0] spike;
    logic [INT8_W-1:0] membrane;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/qlif_ram.sv -----
// ----------------------------------------------------------------------------
// qlif_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qlif_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/quantized_lif_neuron_update.sv -----
// ----------------------------------------------------------------------------
// quantized_lif_neuron_update
// Quantized leaky integrate-and-fire update, one neuron per transaction.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): opcode 0 loads decay_word and
// threshold_word into the channel's table entry and returns nothing;
// opcode 1 updates one neuron and returns one result on the output
// channel (out_valid/out_stall) carrying spike_level and membrane_out.
// Configuration port (cfg_valid/cfg_ready, always ready) writes the zero
// offsets and the input ratio; write it only while the block is idle.
// Throughput: one transaction per cycle while in_stall is low. An update
// passes the table read and offsets, two multiplies, sum and compare, then
// quantize into the queue; results come out in order.
// Results land in an 8-entry queue; in_stall rises from registered state
// once queued plus in-flight results would fill it, so a stalled receiver
// holds back the input only after the queue has taken what is in flight.
// Reset clears the pipeline, the queue and the configuration registers;
// the channel table is not cleared and must be loaded before use.
// A load followed by an update on the same channel in the next cycle sees
// the new entry: the table write lands before the read.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_lif_neuron_update #(
  parameter int CHANNELS = 64,
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic        [qlif_pkg::CHANNEL_W-1:0]   channel,
  input  logic signed [qlif_pkg::INT8_W-1:0]      input_current,
  input  logic signed [qlif_pkg::INT8_W-1:0]      membrane_in,
  input  logic signed [qlif_pkg::DECAY_W-1:0]     decay_word,
  input  logic signed [qlif_pkg::THRESH_W-1:0]    threshold_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [qlif_pkg::INT8_W-1:0]      spike_level,
  output logic signed [qlif_pkg::INT8_W-1:0]      membrane_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [qlif_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic        [qlif_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import qlif_pkg::*;

  localparam int CXW = ((AW > CHANNEL_W) ? AW : CHANNEL_W) + 1;

  // configuration registers
  logic signed [OFFSET_W-1:0] input_zero_offset;
  logic signed [OFFSET_W-1:0] membrane_in_offset;
  logic signed [OFFSET_W-1:0] spike_zero_offset;
  logic signed [OFFSET_W-1:0] membrane_out_offset;
  logic        [RATIO_W-1:0]  input_ratio;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_zero_offset   <= '0;
      membrane_in_offset  <= '0;
      spike_zero_offset   <= '0;
      membrane_out_offset <= '0;
      input_ratio         <= RATIO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INPUT_ZERO:   input_zero_offset   <= cfg_data[OFFSET_W-1:0];
        CFG_MEMBRANE_IN:  membrane_in_offset  <= cfg_data[OFFSET_W-1:0];
        CFG_SPIKE_ZERO:   spike_zero_offset   <= cfg_data[OFFSET_W-1:0];
        CFG_MEMBRANE_OUT: membrane_out_offset <= cfg_data[OFFSET_W-1:0];
        CFG_INPUT_RATIO:  input_ratio         <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // input side and table access
  logic             in_accept;
  logic [CXW-1:0]   chan_x;
  logic             chan_inside;
  logic [AW-1:0]    chan_addr;
  logic             tbl_we;
  logic             tbl_re;
  logic [ENTRY_W-1:0] tbl_rdata;

  assign in_accept   = in_valid && !in_stall;
  assign chan_x      = CXW'(channel);
  assign chan_inside = chan_x < CXW'(CHANNELS);
  assign chan_addr   = chan_x[AW-1:0];
  assign tbl_we      = in_accept && (opcode == OP_LOAD) && chan_inside;
  assign tbl_re      = in_accept && (opcode == OP_UPDATE);

  qlif_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (chan_addr),
    .wdata ({decay_word, threshold_word}),
    .re    (tbl_re),
    .raddr (chan_addr),
    .rdata (tbl_rdata)
  );

  // stage a: offsets applied, table data arrives
  logic                va_valid;
  logic                va_inside;
  logic signed [9:0]   va_m;
  logic signed [9:0]   va_x;
  logic signed [9:0]   m_next;
  logic signed [9:0]   x_next;

  assign m_next = 10'(membrane_in) + 10'(membrane_in_offset);
  assign x_next = 10'(input_current) + 10'(input_zero_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      va_valid <= 1'b0;
    end else begin
      va_valid <= tbl_re;
    end
  end

  always_ff @(posedge clk) begin
    va_inside <= chan_inside;
    va_m      <= m_next;
    va_x      <= x_next;
  end

  // stage b: decay and input products
  logic signed [DECAY_W-1:0]  beta;
  logic signed [THRESH_W-1:0] thr;
  logic signed [25:0]         pb_next;
  logic signed [34:0]         pi_next;
  logic                       vb_valid;
  logic signed [25:0]         vb_pb;
  logic signed [34:0]         vb_pi;
  logic signed [THRESH_W-1:0] vb_thr;

  // channels past the table use zero decay and zero threshold
  assign beta    = va_inside ? tbl_rdata[ENTRY_W-1:THRESH_W] : '0;
  assign thr     = va_inside ? tbl_rdata[THRESH_W-1:0] : '0;
  assign pb_next = 26'(beta) * 26'(va_m);
  assign pi_next = 35'($signed({1'b0, input_ratio})) * 35'(va_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb_valid <= 1'b0;
    end else begin
      vb_valid <= va_valid;
    end
  end

  always_ff @(posedge clk) begin
    vb_pb  <= pb_next;
    vb_pi  <= pi_next;
    vb_thr <= thr;
  end

  // stage c: membrane sum in q.16 and threshold compare
  logic signed [35:0] u_next;
  logic               fire_next;
  logic               vc_valid;
  logic signed [35:0] vc_u;
  logic               vc_fire;

  assign u_next    = (36'(vb_pb) <<< 2) + 36'(vb_pi);
  assign fire_next = 40'(u_next) >= $signed({vb_thr, 8'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      vc_valid <= 1'b0;
    end else begin
      vc_valid <= vb_valid;
    end
  end

  always_ff @(posedge clk) begin
    vc_u    <= u_next;
    vc_fire <= fire_next;
  end

  // quantize: truncate toward zero, remove zero point, saturate
  logic               rnd_up;
  logic signed [20:0] q_trunc;
  logic signed [21:0] q_off;
  logic signed [7:0]  q_sat;
  result_t            res_next;

  assign rnd_up  = vc_u[35] && (|vc_u[15:0]);
  assign q_trunc = 21'($signed(vc_u[35:16])) + 21'(rnd_up);
  assign q_off   = 22'(q_trunc) - 22'(membrane_out_offset);

  always_comb begin
    priority if (q_off > SAT_MAX) begin
      q_sat = 8'(SAT_MAX);
    end else if (q_off < SAT_MIN) begin
      q_sat = 8'(SAT_MIN);
    end else begin
      q_sat = 8'(q_off);
    end
  end

  always_comb begin
    if (vc_fire) begin
      res_next.spike    = 8'(10'(SPIKE_ONE) - 10'(spike_zero_offset));
      res_next.membrane = 8'(10'sd0 - 10'(membrane_out_offset));
    end else begin
      res_next.spike    = 8'(10'sd0 - 10'(spike_zero_offset));
      res_next.membrane = q_sat;
    end
  end

  // result queue
  result_t          res_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic [PTR_W:0]   count_next;
  logic [PTR_W+1:0] committed;
  logic             push;
  logic             pop;

  assign push = vc_valid;
  assign pop  = out_valid && !out_stall;

  // queued plus in-flight results must fit in the queue
  assign committed = (PTR_W+2)'(count) + (PTR_W+2)'(va_valid)
                   + (PTR_W+2)'(vb_valid) + (PTR_W+2)'(vc_valid);
  assign in_stall  = committed >= (PTR_W+2)'(FIFO_DEPTH);

  assign count_next = count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_mem[wr_ptr] <= res_next;
    end
  end

  assign out_valid    = count != '0;
  assign spike_level  = res_mem[rd_ptr].spike;
  assign membrane_out = res_mem[rd_ptr].membrane;

endmodule

`default_nettype wire

// ----- rtl/core/qlif_checker.sv -----
// ----------------------------------------------------------------------------
// qlif_checker
// Port-level checks for the neuron update block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qlif_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                opcode,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [qlif_pkg::INT8_W-1:0]      spike_level,
  input logic signed [qlif_pkg::INT8_W-1:0]      membrane_out
);

  import qlif_pkg::*;

  logic             upd_in;
  logic             res_out;
  logic [PTR_W+1:0] pending;

  assign upd_in  = in_valid && !in_stall && (opcode == OP_UPDATE);
  assign res_out = out_valid && !out_stall;

  // updates accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + (PTR_W+2)'(upd_in) - (PTR_W+2)'(res_out);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(spike_level) && $stable(membrane_out))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("result without an accepted update");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= (PTR_W+2)'(FIFO_DEPTH))
    else $error("more updates outstanding than the result queue holds");

endmodule

bind quantized_lif_neuron_update qlif_checker u_qlif_checker (.*);

`default_nettype wire
